// ===== sv/rpmd_pkg.sv =====
// shared types and constants for the rocker pickup mode detector
package rpmd_pkg;

   localparam int HIST_DEPTH = 64;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int HELD_W     = $clog2(HIST_DEPTH + 1);
   localparam int WIN_W      = 7;
   localparam int CMP_W      = (HELD_W > WIN_W) ? HELD_W : WIN_W;
   localparam int SUM_RAW_W  = $clog2(3 * HIST_DEPTH + 1);
   localparam int SUM_W      = (SUM_RAW_W > 8) ? SUM_RAW_W : 8;
   localparam int CSR_DW     = 8;
   localparam int CSR_IW     = 3;

   localparam logic [CSR_IW-1:0] CSR_TICKS_STABLE  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_EVENTS_STABLE = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_TICKS_LEAVE   = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_EVENTS_LEAVE  = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_TICKS_EVENT   = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_DEBOUNCE      = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_SYNC_DELAY    = 3'd6;

   localparam logic [1:0] ROCK_FAR_LEFT  = 2'd0;
   localparam logic [1:0] ROCK_FAR_RIGHT = 2'd1;
   localparam logic [1:0] ROCK_LEFT      = 2'd2;
   localparam logic [1:0] ROCK_RIGHT     = 2'd3;

   localparam logic [1:0] EDGE_RISE = 2'd1;
   localparam logic [1:0] EDGE_FALL = 2'd2;

   typedef enum logic [2:0] {
      MODE_RADIO_ENTRY  = 3'd0,
      MODE_RADIO_STAY   = 3'd1,
      MODE_PICKUP_ENTRY = 3'd2,
      MODE_PICKUP_STAY  = 3'd3,
      MODE_DIAL_CONTROL = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic movement_level;
      logic fast_level;
      logic left_level;
      logic dial_idle;
      logic pickup_present;
      logic pickup_active;
   } req_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       radio_change;
      logic       radio_on;
      logic       rocker_valid;
      logic [1:0] rocker_code;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic step;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
      logic out_busy;
   } sts_type;

endpackage

// ===== sv/rpmd_ctrl.sv =====
// sequencer: push, history scan, decision, output load
module rpmd_ctrl
   import rpmd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (sts.scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!sts.out_busy) begin
               cmd.decide = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/rpmd_dp.sv =====
// datapath: history memory, window statistics, mode logic, output register
module rpmd_dp
   import rpmd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  req_type           req_data,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   // configuration
   logic [WIN_W-1:0] ts_ff, tl_ff, tew_ff, deb_cfg_ff;
   logic [7:0]       evs_ff, evl_ff, sync_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff      <= 7'd16;
         evs_ff     <= 8'd4;
         tl_ff      <= 7'd32;
         evl_ff     <= 8'd2;
         tew_ff     <= 7'd16;
         deb_cfg_ff <= 7'd3;
         sync_ff    <= 8'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TICKS_STABLE:  ts_ff      <= csr_wdata[WIN_W-1:0];
            CSR_EVENTS_STABLE: evs_ff     <= csr_wdata;
            CSR_TICKS_LEAVE:   tl_ff      <= csr_wdata[WIN_W-1:0];
            CSR_EVENTS_LEAVE:  evl_ff     <= csr_wdata;
            CSR_TICKS_EVENT:   tew_ff     <= csr_wdata[WIN_W-1:0];
            CSR_DEBOUNCE:      deb_cfg_ff <= csr_wdata[WIN_W-1:0];
            CSR_SYNC_DELAY:    sync_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // history memory: {edges, levels}
   logic [8:0]         hist_mem [HIST_DEPTH];
   logic [HIST_AW-1:0] newest_ff, newest_in;
   logic [HELD_W-1:0]  held_ff;
   logic [2:0]         last_lvl_ff, lvl_in;
   logic [5:0]         edge_in;
   logic               dial_ff, present_ff, active_ff;

   assign lvl_in    = {req_data.left_level, req_data.fast_level, req_data.movement_level};
   assign newest_in = (newest_ff == HIST_AW'(HIST_DEPTH - 1)) ? '0 : newest_ff + 1'b1;

   always_comb begin
      edge_in = '0;
      if (held_ff != '0) begin
         for (int c = 0; c < 3; c++) begin
            if (lvl_in[c] && !last_lvl_ff[c]) begin
               edge_in[2*c +: 2] = EDGE_RISE;
            end else if (!lvl_in[c] && last_lvl_ff[c]) begin
               edge_in[2*c +: 2] = EDGE_FALL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         hist_mem[newest_in] <= {edge_in, lvl_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff <= '0;
         held_ff   <= '0;
      end else if (cmd.push) begin
         newest_ff <= newest_in;
         if (held_ff != HELD_W'(HIST_DEPTH)) begin
            held_ff <= held_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         last_lvl_ff <= lvl_in;
         dial_ff     <= req_data.dial_idle;
         present_ff  <= req_data.pickup_present;
         active_ff   <= req_data.pickup_active;
      end
   end

   // scan, newest sample first
   logic [CMP_W-1:0]   held_x, ts_x, tl_x, tew_x, nev_x, max_x, len_x;
   logic [HELD_W-1:0]  idx_ff;
   logic [HELD_W:0]    addr_w;
   logic [HIST_AW-1:0] rd_addr;
   logic [8:0]         rd_data_ff;
   logic [HELD_W-1:0]  rd_idx_ff;
   logic               rd_vld_ff;
   logic               issue;

   assign held_x = CMP_W'(held_ff);
   assign ts_x   = CMP_W'(ts_ff);
   assign tl_x   = CMP_W'(tl_ff);
   assign tew_x  = CMP_W'(tew_ff);
   assign nev_x  = (held_x < tew_x) ? held_x : tew_x;

   always_comb begin
      max_x = (ts_x > tl_x) ? ts_x : tl_x;
      if (tew_x > max_x) begin
         max_x = tew_x;
      end
      len_x = (held_x < max_x) ? held_x : max_x;
   end

   assign sts.scan_end = CMP_W'(idx_ff) >= len_x;
   assign issue        = cmd.step && !sts.scan_end;

   always_comb begin
      if ({1'b0, HELD_W'(newest_ff)} >= {1'b0, idx_ff}) begin
         addr_w = (HELD_W+1)'(newest_ff) - (HELD_W+1)'(idx_ff);
      end else begin
         addr_w = (HELD_W+1)'(newest_ff) + (HELD_W+1)'(HIST_DEPTH) - (HELD_W+1)'(idx_ff);
      end
      rd_addr = addr_w[HIST_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= hist_mem[rd_addr];
         rd_idx_ff  <= idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         if (cmd.push) begin
            idx_ff <= '0;
         end else if (issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // accumulators: debounce runs are shared by all windows
   logic [HELD_W-1:0] deb_ff  [3];
   logic [HELD_W-1:0] deb_in  [3];
   logic [SUM_W-1:0]  st3_ff, st02_ff, lv02_ff, st3_in, st02_in, lv02_in;
   logic              st_ev0_ff, st_ev0_in;
   logic [2:0]        evw_ff, evw_in, hit;
   logic [2:0]        edg;
   logic [CMP_W-1:0]  j_x;

   always_comb begin
      j_x = CMP_W'(rd_idx_ff);
      for (int c = 0; c < 3; c++) begin
         deb_in[c] = deb_ff[c];
         hit[c]    = 1'b0;
         edg[c]    = 1'b0;
         if (rd_data_ff[3 + 2*c +: 2] == EDGE_RISE) begin
            edg[c]    = 1'b1;
            deb_in[c] = '0;
         end else if (rd_data_ff[3 + 2*c +: 2] == EDGE_FALL) begin
            edg[c] = 1'b1;
         end else begin
            deb_in[c] = deb_ff[c] + HELD_W'(rd_data_ff[c]);
            hit[c]    = CMP_W'(deb_in[c]) >= CMP_W'(deb_cfg_ff);
         end
      end
      st3_in    = st3_ff;
      st02_in   = st02_ff;
      lv02_in   = lv02_ff;
      st_ev0_in = st_ev0_ff;
      evw_in    = evw_ff;
      if (j_x < ts_x) begin
         st3_in    = st3_ff + SUM_W'(edg[0]) + SUM_W'(edg[1]) + SUM_W'(edg[2]);
         st02_in   = st02_ff + SUM_W'(edg[0]) + SUM_W'(edg[2]);
         st_ev0_in = st_ev0_ff | hit[0];
      end
      if (j_x < tl_x) begin
         lv02_in = lv02_ff + SUM_W'(edg[0]) + SUM_W'(edg[2]);
      end
      if (j_x < nev_x) begin
         evw_in = evw_ff | hit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         for (int c = 0; c < 3; c++) begin
            deb_ff[c] <= '0;
         end
         st3_ff    <= '0;
         st02_ff   <= '0;
         lv02_ff   <= '0;
         st_ev0_ff <= 1'b0;
         evw_ff    <= '0;
      end else if (rd_vld_ff) begin
         for (int c = 0; c < 3; c++) begin
            deb_ff[c] <= deb_in[c];
         end
         st3_ff    <= st3_in;
         st02_ff   <= st02_in;
         lv02_ff   <= lv02_in;
         st_ev0_ff <= st_ev0_in;
         evw_ff    <= evw_in;
      end
   end

   // mode decision
   mode_type   mode_ff, mode_in;
   logic [7:0] ecnt_ff, ecnt_in, scnt_ff, scnt_in, idle_ff, idle_in;
   logic       eseen_ff, eseen_in, sseen_ff, sseen_in;
   logic       chg, on, rv;
   logic [1:0] code;
   logic       handled, done, stable, leave, st_ok, lv_ok;
   logic [7:0] cnt;
   logic       seen;
   logic [SUM_W-1:0] evs_x, evl_x;

   assign evs_x = SUM_W'(evs_ff);
   assign evl_x = SUM_W'(evl_ff);
   assign st_ok = held_x >= ts_x;
   assign lv_ok = held_x >= tl_x;

   always_comb begin
      mode_in  = mode_ff;
      ecnt_in  = ecnt_ff;
      eseen_in = eseen_ff;
      scnt_in  = scnt_ff;
      sseen_in = sseen_ff;
      idle_in  = idle_ff;
      chg      = 1'b0;
      on       = 1'b0;
      rv       = 1'b0;
      code     = ROCK_FAR_LEFT;
      handled  = 1'b0;
      done     = 1'b0;
      stable   = 1'b0;
      leave    = 1'b0;
      cnt      = '0;
      seen     = 1'b0;
      if (mode_ff == MODE_DIAL_CONTROL) begin
         if (dial_ff) begin
            idle_in = (idle_ff == 8'hFF) ? idle_ff : idle_ff + 1'b1;
         end else begin
            idle_in = '0;
         end
         if (idle_in > 8'(tl_ff)) begin
            mode_in = MODE_RADIO_ENTRY;
            chg     = 1'b1;
            on      = 1'b1;
         end
      end else begin
         // direct dial and pickup inputs override the statistics
         if (!dial_ff) begin
            mode_in = MODE_DIAL_CONTROL;
            idle_in = '0;
            handled = 1'b1;
         end else if (present_ff) begin
            handled = 1'b1;
            if (active_ff) begin
               if (mode_ff != MODE_PICKUP_STAY) begin
                  mode_in  = MODE_PICKUP_STAY;
                  scnt_in  = '0;
                  sseen_in = 1'b0;
                  chg      = 1'b1;
               end
            end else if (mode_ff != MODE_RADIO_STAY) begin
               mode_in = MODE_RADIO_STAY;
               chg     = 1'b1;
               on      = 1'b1;
            end
         end
         if (mode_ff == MODE_PICKUP_ENTRY || mode_ff == MODE_PICKUP_STAY) begin
            if (!handled) begin
               leave = lv_ok && (lv02_ff > evl_x);
               if (mode_ff == MODE_PICKUP_ENTRY) begin
                  stable = st_ok && (st02_ff <= evs_x);
                  if (stable) begin
                     mode_in  = MODE_PICKUP_STAY;
                     scnt_in  = '0;
                     sseen_in = 1'b0;
                     done     = 1'b1;
                  end else if (leave) begin
                     mode_in = MODE_RADIO_ENTRY;
                     chg     = 1'b1;
                     on      = 1'b1;
                     done    = 1'b1;
                  end
               end else begin
                  stable = !st_ok || (st02_ff <= evs_x) || st_ev0_ff;
                  if (leave) begin
                     mode_in = MODE_RADIO_ENTRY;
                     chg     = 1'b1;
                     on      = 1'b1;
                     done    = 1'b1;
                  end else if (!stable) begin
                     mode_in  = MODE_PICKUP_ENTRY;
                     ecnt_in  = '0;
                     eseen_in = 1'b0;
                     done     = 1'b1;
                  end
               end
            end
            if (!done) begin
               // rocker event on the hold counter of the mode we started in
               if (mode_ff == MODE_PICKUP_ENTRY) begin
                  cnt  = ecnt_in;
                  seen = eseen_in;
               end else begin
                  cnt  = scnt_in;
                  seen = sseen_in;
               end
               if (!evw_ff[0]) begin
                  cnt  = '0;
                  seen = 1'b0;
               end else begin
                  if (cnt != 8'hFF) begin
                     cnt = cnt + 1'b1;
                  end
                  if (cnt >= sync_ff && !seen) begin
                     seen = 1'b1;
                     rv   = 1'b1;
                     if (evw_ff[1]) begin
                        code = evw_ff[2] ? ROCK_FAR_LEFT : ROCK_FAR_RIGHT;
                     end else begin
                        code = evw_ff[2] ? ROCK_LEFT : ROCK_RIGHT;
                     end
                  end
               end
               if (mode_ff == MODE_PICKUP_ENTRY) begin
                  ecnt_in  = cnt;
                  eseen_in = seen;
               end else begin
                  scnt_in  = cnt;
                  sseen_in = seen;
               end
            end
         end else if (!handled) begin
            leave = lv_ok && (lv02_ff <= evl_x);
            if (mode_ff == MODE_RADIO_STAY) begin
               stable = !st_ok || (st3_ff > evs_x);
               if (leave) begin
                  mode_in  = MODE_PICKUP_ENTRY;
                  ecnt_in  = '0;
                  eseen_in = 1'b0;
                  chg      = 1'b1;
               end else if (!stable) begin
                  mode_in = MODE_RADIO_ENTRY;
               end
            end else begin
               stable = st_ok && (st3_ff > evs_x);
               if (stable) begin
                  mode_in = MODE_RADIO_STAY;
               end else if (leave) begin
                  mode_in  = MODE_PICKUP_ENTRY;
                  ecnt_in  = '0;
                  eseen_in = 1'b0;
                  chg      = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RADIO_ENTRY;
         ecnt_ff  <= '0;
         eseen_ff <= 1'b0;
         scnt_ff  <= '0;
         sseen_ff <= 1'b0;
         idle_ff  <= '0;
      end else if (cmd.decide) begin
         mode_ff  <= mode_in;
         ecnt_ff  <= ecnt_in;
         eseen_ff <= eseen_in;
         scnt_ff  <= scnt_in;
         sseen_ff <= sseen_in;
         idle_ff  <= idle_in;
      end
   end

   // output word register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.decide) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_data_ff.mode         <= mode_in;
         rsp_data_ff.radio_change <= chg;
         rsp_data_ff.radio_on     <= on;
         rsp_data_ff.rocker_valid <= rv;
         rsp_data_ff.rocker_code  <= code;
      end
   end

   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

// ===== sv/rocker_pickup_mode_detector.sv =====
// rocker pickup mode detector top level
// operation: an accepted word is pushed into the history, then the newest
//   L = min(samples held, largest of the three window registers) samples,
//   at most 64, are scanned one sample per cycle; the decision then loads the
//   output register, waiting while it stalls; only then is a new word taken
// reset: synchronous, clears mode, counters, fill count and config to defaults
module rocker_pickup_mode_detector
   import rpmd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   rpmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rpmd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/rpmd_checker.sv =====
// port checker for the rocker pickup mode detector, bound to the top level
module rpmd_checker
   import rpmd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word dropped or changed while stalled");

   a_on_needs_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.radio_on |-> rsp_data.radio_change)
      else $error("radio_on without radio_change");

   a_code_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.rocker_valid |-> rsp_data.rocker_code == ROCK_FAR_LEFT)
      else $error("rocker code set without event");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted while previous one in work");

endmodule

bind rocker_pickup_mode_detector rpmd_checker u_rpmd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== bench/tb.sv =====
// testbench for the rocker pickup mode detector: directed and random ticks checked against a predictor
module tb;
   import rpmd_pkg::*;

   localparam int WATCH_LIMIT = 4000;

   typedef struct packed {
      logic            ok;
      logic [2:0][7:0] edges;
      logic [2:0]      ev;
   } win_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_we;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;

   // predictor state
   logic [2:0] lvl_mem [HIST_DEPTH];
   logic [5:0] edge_mem [HIST_DEPTH];
   int         head;
   int         held;
   mode_type   cur_mode;
   int         entry_cnt;
   bit         entry_seen;
   int         stay_cnt;
   bit         stay_seen;
   int         idle_cnt;
   int         reg_val [7];
   rsp_type    pred;

   rsp_type    rsp_q [$];
   int         errors;
   int         words_sent;
   int         words_checked;
   int         settings_used;
   int         quiet_cnt;
   bit         ready_burst;

   rocker_pickup_mode_detector u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic win_type scan_window(int n);
      win_type s;
      int      deb [3];
      int      idx;
      logic [1:0] e;
      s = '0;
      deb = '{0, 0, 0};
      if (held < n)
         return s;
      for (int i = 0; i < n; i++) begin
         idx = (head + HIST_DEPTH - i) % HIST_DEPTH;
         for (int c = 0; c < 3; c++) begin
            e = edge_mem[idx][2*c +: 2];
            if (e == EDGE_RISE) begin
               s.edges[c] = s.edges[c] + 1;
               deb[c] = 0;
            end else if (e == EDGE_FALL) begin
               s.edges[c] = s.edges[c] + 1;
            end else begin
               if (lvl_mem[idx][c])
                  deb[c]++;
               if (deb[c] >= reg_val[CSR_DEBOUNCE])
                  s.ev[c] = 1'b1;
            end
         end
      end
      s.ok = 1'b1;
      return s;
   endfunction

   function automatic void enter_mode(mode_type m);
      cur_mode = m;
      if (m == MODE_PICKUP_ENTRY) begin
         entry_cnt = 0;
         entry_seen = 0;
      end else if (m == MODE_PICKUP_STAY) begin
         stay_cnt = 0;
         stay_seen = 0;
      end else if (m == MODE_DIAL_CONTROL) begin
         idle_cnt = 0;
      end
   endfunction

   function automatic void report_radio(bit on);
      pred.radio_change = 1'b1;
      pred.radio_on = on;
   endfunction

   // dial and direct pickup checks ahead of the window tests
   function automatic bit direct_checks(req_type w);
      if (!w.dial_idle) begin
         enter_mode(MODE_DIAL_CONTROL);
         return 1;
      end
      if (!w.pickup_present)
         return 0;
      if (w.pickup_active) begin
         if (cur_mode != MODE_PICKUP_STAY) begin
            enter_mode(MODE_PICKUP_STAY);
            report_radio(0);
         end
      end else if (cur_mode != MODE_RADIO_STAY) begin
         enter_mode(MODE_RADIO_STAY);
         report_radio(1);
      end
      return 1;
   endfunction

   function automatic void rocker_scan(bit in_stay);
      win_type s;
      int      n;
      int      cnt;
      bit      seen;
      n = (held > reg_val[CSR_TICKS_EVENT]) ? reg_val[CSR_TICKS_EVENT] : held;
      s = scan_window(n);
      if (!s.ok)
         return;
      cnt = in_stay ? stay_cnt : entry_cnt;
      seen = in_stay ? stay_seen : entry_seen;
      if (!s.ev[0]) begin
         cnt = 0;
         seen = 0;
      end else begin
         if (cnt < 255)
            cnt++;
         if (cnt >= reg_val[CSR_SYNC_DELAY] && !seen) begin
            seen = 1;
            pred.rocker_valid = 1'b1;
            if (s.ev[1])
               pred.rocker_code = s.ev[2] ? ROCK_FAR_LEFT : ROCK_FAR_RIGHT;
            else
               pred.rocker_code = s.ev[2] ? ROCK_LEFT : ROCK_RIGHT;
         end
      end
      if (in_stay) begin
         stay_cnt = cnt;
         stay_seen = seen;
      end else begin
         entry_cnt = cnt;
         entry_seen = seen;
      end
   endfunction

   function automatic rsp_type next_mode_word(req_type w);
      logic [2:0] lv;
      logic [5:0] ed;
      int         prev;
      mode_type   m;
      win_type    st;
      win_type    lw;
      bit         stable;
      bit         leave;
      bit         done;
      int         sum_st;
      int         sum_lv;
      pred = '0;
      lv = {w.left_level, w.fast_level, w.movement_level};
      prev = head;
      head = (head + 1) % HIST_DEPTH;
      lvl_mem[head] = lv;
      if (held < HIST_DEPTH)
         held++;
      ed = '0;
      if (held > 1) begin
         for (int c = 0; c < 3; c++) begin
            if (lv[c] && !lvl_mem[prev][c])
               ed[2*c +: 2] = EDGE_RISE;
            else if (!lv[c] && lvl_mem[prev][c])
               ed[2*c +: 2] = EDGE_FALL;
         end
      end
      edge_mem[head] = ed;
      m = cur_mode;
      if (m == MODE_DIAL_CONTROL) begin
         if (w.dial_idle) begin
            if (idle_cnt < 255)
               idle_cnt++;
         end else begin
            idle_cnt = 0;
         end
         if (idle_cnt > reg_val[CSR_TICKS_LEAVE]) begin
            enter_mode(MODE_RADIO_ENTRY);
            report_radio(1);
         end
      end else if (m != MODE_PICKUP_ENTRY && m != MODE_PICKUP_STAY) begin
         if (!direct_checks(w)) begin
            st = scan_window(reg_val[CSR_TICKS_STABLE]);
            lw = scan_window(reg_val[CSR_TICKS_LEAVE]);
            sum_st = st.edges[0] + st.edges[1] + st.edges[2];
            leave = lw.ok && (lw.edges[0] + lw.edges[2]) <= reg_val[CSR_EVENTS_LEAVE];
            if (m == MODE_RADIO_STAY) begin
               stable = !st.ok || sum_st > reg_val[CSR_EVENTS_STABLE];
               if (leave) begin
                  enter_mode(MODE_PICKUP_ENTRY);
                  report_radio(0);
               end else if (!stable) begin
                  enter_mode(MODE_RADIO_ENTRY);
               end
            end else begin
               stable = st.ok && sum_st > reg_val[CSR_EVENTS_STABLE];
               if (stable) begin
                  enter_mode(MODE_RADIO_STAY);
               end else if (leave) begin
                  enter_mode(MODE_PICKUP_ENTRY);
                  report_radio(0);
               end
            end
         end
      end else begin
         done = 0;
         if (!direct_checks(w)) begin
            st = scan_window(reg_val[CSR_TICKS_STABLE]);
            lw = scan_window(reg_val[CSR_TICKS_LEAVE]);
            sum_st = st.edges[0] + st.edges[2];
            sum_lv = lw.edges[0] + lw.edges[2];
            leave = lw.ok && sum_lv > reg_val[CSR_EVENTS_LEAVE];
            if (m == MODE_PICKUP_ENTRY) begin
               stable = st.ok && sum_st <= reg_val[CSR_EVENTS_STABLE];
               if (stable) begin
                  enter_mode(MODE_PICKUP_STAY);
                  done = 1;
               end else if (leave) begin
                  enter_mode(MODE_RADIO_ENTRY);
                  report_radio(1);
                  done = 1;
               end
            end else begin
               stable = !st.ok || sum_st <= reg_val[CSR_EVENTS_STABLE] || st.ev[0];
               if (leave) begin
                  enter_mode(MODE_RADIO_ENTRY);
                  report_radio(1);
                  done = 1;
               end else if (!stable) begin
                  enter_mode(MODE_PICKUP_ENTRY);
                  done = 1;
               end
            end
         end
         // a pickup mode left by the direct checks still runs its rocker scan
         if (!done)
            rocker_scan(m == MODE_PICKUP_STAY);
      end
      pred.mode = cur_mode;
      return pred;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (rsp_q.size() == 0) begin
            $error("unexpected word: %h", rsp_data);
            errors++;
         end else begin
            want = rsp_q.pop_front();
            if (rsp_data.mode !== want.mode) begin
               $error("mode: expected %0d, got %0d", want.mode, rsp_data.mode);
               errors++;
            end
            if (rsp_data.radio_change !== want.radio_change) begin
               $error("radio_change: expected %0d, got %0d",
                      want.radio_change, rsp_data.radio_change);
               errors++;
            end
            if (rsp_data.radio_on !== want.radio_on) begin
               $error("radio_on: expected %0d, got %0d", want.radio_on, rsp_data.radio_on);
               errors++;
            end
            if (rsp_data.rocker_valid !== want.rocker_valid) begin
               $error("rocker_valid: expected %0d, got %0d",
                      want.rocker_valid, rsp_data.rocker_valid);
               errors++;
            end
            if (rsp_data.rocker_code !== want.rocker_code) begin
               $error("rocker_code: expected %0d, got %0d",
                      want.rocker_code, rsp_data.rocker_code);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no word accepted
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cnt <= 0;
      end else if (quiet_cnt >= WATCH_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cnt <= quiet_cnt + 1;
      end
   end

   // result side stalls
   initial begin
      int n;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         n = ready_burst ? 0 : $urandom_range(0, 16);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_word(req_type w, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      rsp_q.push_back(next_mode_word(w));
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (rsp_q.size() != 0)
         @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TICKS_STABLE || idx == CSR_TICKS_LEAVE || idx == CSR_TICKS_EVENT
          || idx == CSR_DEBOUNCE)
         reg_val[idx] = val & 8'h7f;
      else if (idx <= CSR_SYNC_DELAY)
         reg_val[idx] = val;
   endtask

   task automatic set_all(int ts, int es, int tl, int el, int te, int db, int sd);
      drain();
      write_reg(CSR_TICKS_STABLE, CSR_DW'(ts));
      write_reg(CSR_EVENTS_STABLE, CSR_DW'(es));
      write_reg(CSR_TICKS_LEAVE, CSR_DW'(tl));
      write_reg(CSR_EVENTS_LEAVE, CSR_DW'(el));
      write_reg(CSR_TICKS_EVENT, CSR_DW'(te));
      write_reg(CSR_DEBOUNCE, CSR_DW'(db));
      write_reg(CSR_SYNC_DELAY, CSR_DW'(sd));
      settings_used++;
   endtask

   function automatic req_type mk(bit mv, bit fa, bit le, bit di, bit pp, bit pa);
      req_type w;
      w.movement_level = mv;
      w.fast_level = fa;
      w.left_level = le;
      w.dial_idle = di;
      w.pickup_present = pp;
      w.pickup_active = pa;
      return w;
   endfunction

   // default settings: first word has no edges; too few words fill no window, so the mode stays radio entry
   task automatic test_defaults();
      send_word(mk(1, 1, 1, 1, 0, 0));
      send_word(mk(0, 0, 0, 1, 0, 0));
      send_word(mk(1, 0, 1, 1, 0, 0));
      repeat (4) send_word(mk(1, 1, 1, 1, 0, 0));
      repeat (4) send_word(mk(1, 0, 0, 1, 0, 0));
   endtask

   // direct pickup switch and entry into dial control
   task automatic test_direct_and_dial();
      send_word(mk(1, 0, 1, 1, 1, 1));
      send_word(mk(1, 0, 1, 1, 1, 1));
      send_word(mk(0, 1, 0, 1, 1, 0));
      send_word(mk(0, 1, 0, 1, 1, 0));
      send_word(mk(0, 0, 0, 0, 1, 1));
      send_word(mk(1, 1, 1, 0, 0, 0));
      send_word(mk(1, 1, 0, 1, 0, 0));
   endtask

   // one-sample windows, zero event limits, zero debounce, zero sync delay, then out-of-range index and masked values
   task automatic test_extremes();
      set_all(1, 0, 1, 0, 1, 0, 0);
      write_reg(3'd7, 8'hff);
      repeat (4) send_word(mk(1'($urandom), 1'($urandom), 1'($urandom), 1, 0, 0));
      set_all(8'h80, 192, 8'hc0, 192, 8'hc0, 8'hc0, 255);
      repeat (4) send_word(mk(1'($urandom), 1'($urandom), 1'($urandom), 1, 0, 0));
   endtask

   // segments of quiet holds with rocker pulses, busy toggling, dial use and direct pickup
   task automatic test_random(int count);
      int seg;
      int len;
      bit mv;
      bit fa;
      bit le;
      int sent;
      sent = 0;
      while (sent < count) begin
         seg = $urandom_range(0, 9);
         len = $urandom_range(3, 40);
         ready_burst = ($urandom_range(0, 5) == 0);
         fa = 1'($urandom);
         le = 1'($urandom);
         for (int i = 0; i < len; i++) begin
            if (seg <= 4) begin
               // quiet hold with occasional movement pulse
               mv = (i % 12) < ($urandom_range(0, 6));
               send_word(mk(mv, fa, le, 1, 0, 1'($urandom)), ready_burst);
            end else if (seg <= 6) begin
               send_word(mk(1'($urandom), 1'($urandom), 1'($urandom), 1, 0, 1'($urandom)),
                         ready_burst);
            end else if (seg == 7) begin
               send_word(mk(1'($urandom), fa, le, (i > 2), 0, 1'($urandom)), ready_burst);
            end else if (seg == 8) begin
               send_word(mk(1'($urandom), 1'($urandom), 1'($urandom),
                            $urandom_range(0, 9) != 0,
                            1'($urandom), 1'($urandom)), ready_burst);
            end else begin
               send_word(mk(1, fa, le, 1, ($urandom_range(0, 3) == 0), 1'($urandom)),
                         ready_burst);
            end
         end
         sent += len;
      end
      ready_burst = 0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      ready_burst = 0;
      errors = 0;
      words_sent = 0;
      words_checked = 0;
      settings_used = 1;
      reg_val = '{16, 4, 32, 2, 16, 3, 2};
      for (int i = 0; i < HIST_DEPTH; i++) begin
         lvl_mem[i] = '0;
         edge_mem[i] = '0;
      end
      head = 0;
      held = 0;
      cur_mode = MODE_RADIO_ENTRY;
      entry_cnt = 0;
      entry_seen = 0;
      stay_cnt = 0;
      stay_seen = 0;
      idle_cnt = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_defaults();
      test_direct_and_dial();
      test_extremes();

      set_all(16, 4, 32, 2, 16, 3, 2);
      test_random(400);
      drain();
      test_random(200);
      set_all(4, 2, 8, 1, 4, 1, 0);
      test_random(300);
      set_all(1, 0, 1, 0, 1, 0, 0);
      test_random(150);
      set_all(64, 192, 64, 192, 64, 64, 255);
      test_random(150);
      for (int k = 0; k < 4; k++) begin
         set_all($urandom_range(1, 24), $urandom_range(0, 8), $urandom_range(1, 40),
                 $urandom_range(0, 6), $urandom_range(1, 24), $urandom_range(0, 6),
                 $urandom_range(0, 6));
         test_random(150);
      end

      drain();
      $display("tb: %0d words sent, %0d results checked, %0d register settings",
               words_sent, words_checked, settings_used);
      $display("tb: covered direct pickup, dial timeout, window limits and rocker codes");
      if (errors == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
